/* rtl/trl3_pkg.sv */
// Shared constants and types for the three-anchor trilateration block.
package trl3_pkg;

	localparam int COORD_WIDTH_DEF = 24;

	// Depth of the queue between front and back (power of two).
	localparam int MID_DEPTH = 4;
	// Depth of the result queue (power of two).
	localparam int OUT_DEPTH = 2;

	typedef enum logic [1:0] {
		ST_SOLVED    = 2'd0,
		ST_SINGULAR  = 2'd1,
		ST_SATURATED = 2'd2
	} fix_status_t;

endpackage

/* rtl/trilateration_three_anchor_top.sv */
// Top level of the three-anchor linearized 2-D trilateration block.
//
// Each request carries anchors A and B, a reference anchor and the three measured
// ranges; the block answers with one position fix per request, in order. It takes
// one request per clock while full is low: the front part builds the 2x2 system
// over two stages and drops it into a four-entry queue; the back part forms the
// determinant and Cramer numerators (split partial products, one multiplier level
// per stage), takes magnitudes, checks for overflow, then runs a restoring divider
// with one stage per quotient bit (COORD_WIDTH+1 stages) and saturates. When the
// result queue is full the whole back part holds; full rises once the front queue
// plus the requests still in the front stages would fill it. A zero determinant
// gives a zero position with status singular; a clamped coordinate gives status
// saturated. Reset clears only control state, no clearing pass is needed.
module trilateration_three_anchor_top #(
	parameter int COORD_WIDTH = trl3_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [COORD_WIDTH-1:0] anchor_a_x,
	input  logic signed [COORD_WIDTH-1:0] anchor_a_y,
	input  logic [COORD_WIDTH-2:0]        range_a,
	input  logic signed [COORD_WIDTH-1:0] anchor_b_x,
	input  logic signed [COORD_WIDTH-1:0] anchor_b_y,
	input  logic [COORD_WIDTH-2:0]        range_b,
	input  logic signed [COORD_WIDTH-1:0] ref_anchor_x,
	input  logic signed [COORD_WIDTH-1:0] ref_anchor_y,
	input  logic [COORD_WIDTH-2:0]        ref_range,
	input  logic                          pop,
	output logic                          empty,
	output logic signed [COORD_WIDTH-1:0] pos_x,
	output logic signed [COORD_WIDTH-1:0] pos_y,
	output logic [1:0]                    fix_status
);

	localparam int CW  = COORD_WIDTH;
	localparam int AW  = CW + 2;
	localparam int BW  = 2 * CW + 2;
	localparam int MW  = 4 * AW + 2 * BW;
	localparam int OW  = 2 * CW + 2;
	localparam int MPW = $clog2(trl3_pkg::MID_DEPTH);
	localparam int OPW = $clog2(trl3_pkg::OUT_DEPTH);

	logic                 push_ok;
	logic                 f_valid;
	logic signed [AW-1:0] f_a11, f_a12, f_a21, f_a22;
	logic signed [BW-1:0] f_b1, f_b2;
	logic [1:0]           f_inflight;

	logic [MW-1:0]  mid_rd_data;
	logic [MPW:0]   mid_count;
	logic [MPW+1:0] mid_credit;
	logic           mid_take;

	logic                 back_en;
	logic                 out_wr;
	logic signed [CW-1:0] r_pos_x, r_pos_y;
	logic [1:0]           r_status;
	logic [OW-1:0]        out_rd_data;
	logic [OPW:0]         out_count;

	assign push_ok = push && !full;

	// requests already in flight in the front stages hold a queue slot
	assign mid_credit = (MPW+2)'(mid_count) + (MPW+2)'(f_inflight);
	assign full       = mid_credit >= (MPW+2)'(trl3_pkg::MID_DEPTH);

	trl3_front #(.CW(CW)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (push_ok),
		.anchor_a_x   (anchor_a_x),
		.anchor_a_y   (anchor_a_y),
		.range_a      (range_a),
		.anchor_b_x   (anchor_b_x),
		.anchor_b_y   (anchor_b_y),
		.range_b      (range_b),
		.ref_anchor_x (ref_anchor_x),
		.ref_anchor_y (ref_anchor_y),
		.ref_range    (ref_range),
		.out_valid    (f_valid),
		.out_a11      (f_a11),
		.out_a12      (f_a12),
		.out_a21      (f_a21),
		.out_a22      (f_a22),
		.out_b1       (f_b1),
		.out_b2       (f_b2),
		.inflight     (f_inflight)
	);

	trl3_fifo #(.WIDTH(MW), .DEPTH(trl3_pkg::MID_DEPTH)) u_mid_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (f_valid),
		.wr_data ({f_a11, f_a12, f_a21, f_a22, f_b1, f_b2}),
		.rd_en   (mid_take),
		.rd_data (mid_rd_data),
		.count   (mid_count)
	);

	// back part runs whenever the result queue has a free slot
	assign back_en = out_count != (OPW+1)'(trl3_pkg::OUT_DEPTH);

	trl3_back #(.CW(CW)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (back_en),
		.in_avail   (mid_count != '0),
		.in_a11     (mid_rd_data[MW-1 -: AW]),
		.in_a12     (mid_rd_data[MW-AW-1 -: AW]),
		.in_a21     (mid_rd_data[MW-2*AW-1 -: AW]),
		.in_a22     (mid_rd_data[MW-3*AW-1 -: AW]),
		.in_b1      (mid_rd_data[2*BW-1 -: BW]),
		.in_b2      (mid_rd_data[BW-1:0]),
		.in_take    (mid_take),
		.out_valid  (out_wr),
		.out_pos_x  (r_pos_x),
		.out_pos_y  (r_pos_y),
		.out_status (r_status)
	);

	trl3_fifo #(.WIDTH(OW), .DEPTH(trl3_pkg::OUT_DEPTH)) u_out_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (out_wr),
		.wr_data ({r_pos_x, r_pos_y, r_status}),
		.rd_en   (pop && !empty),
		.rd_data (out_rd_data),
		.count   (out_count)
	);

	assign empty      = out_count == '0;
	assign pos_x      = out_rd_data[OW-1 -: CW];
	assign pos_y      = out_rd_data[CW+1 -: CW];
	assign fix_status = out_rd_data[1:0];

`ifndef NO_ASSERTIONS
	// front stages never write into a full queue
	a_mid_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(f_valid && mid_count == (MPW+1)'(trl3_pkg::MID_DEPTH)))
		else $error("front queue overflow");

	// the credit scheme keeps queued plus in-flight requests within the queue
	a_mid_credit: assert property (@(posedge clk) disable iff (!arst_n)
		mid_credit <= (MPW+2)'(trl3_pkg::MID_DEPTH))
		else $error("front credit exceeded");

	// back part never writes a result into a full result queue
	a_out_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_wr && out_count == (OPW+1)'(trl3_pkg::OUT_DEPTH)))
		else $error("result queue overflow");

	// status code three is never produced
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_wr |-> (r_status != 2'd3))
		else $error("invalid fix status");
`endif

endmodule

/* rtl/trl3_fifo.sv */
// Small register queue with show-ahead read, used between front and back and for results.
module trl3_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [WIDTH-1:0]           wr_data,
	input  logic                       rd_en,
	output logic [WIDTH-1:0]           rd_data,
	output logic [$clog2(DEPTH):0]     count
);

	localparam int PW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wp_q;
	logic [PW-1:0]    rp_q;
	logic [PW:0]      cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wp_q <= wp_q + PW'(1);
			end
			if (rd_en) begin
				rp_q <= rp_q + PW'(1);
			end
			cnt_q <= cnt_q + (PW+1)'(wr_en) - (PW+1)'(rd_en);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	assign rd_data = mem_q[rp_q];
	assign count   = cnt_q;

endmodule

/* rtl/trl3_front.sv */
// Front part: takes requests, forms the linear system rows and right-hand sides.
module trl3_front #(
	parameter  int CW = trl3_pkg::COORD_WIDTH_DEF,
	localparam int AW = CW + 2,
	localparam int BW = 2 * CW + 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic signed [CW-1:0] anchor_a_x,
	input  logic signed [CW-1:0] anchor_a_y,
	input  logic [CW-2:0]        range_a,
	input  logic signed [CW-1:0] anchor_b_x,
	input  logic signed [CW-1:0] anchor_b_y,
	input  logic [CW-2:0]        range_b,
	input  logic signed [CW-1:0] ref_anchor_x,
	input  logic signed [CW-1:0] ref_anchor_y,
	input  logic [CW-2:0]        ref_range,
	output logic                 out_valid,
	output logic signed [AW-1:0] out_a11,
	output logic signed [AW-1:0] out_a12,
	output logic signed [AW-1:0] out_a21,
	output logic signed [AW-1:0] out_a22,
	output logic signed [BW-1:0] out_b1,
	output logic signed [BW-1:0] out_b2,
	output logic [1:0]           inflight
);

	localparam int SW = 2 * CW;
	localparam int RW = 2 * CW - 2;

	logic signed [AW-1:0] dxa, dya, dxb, dyb;

	logic                 v_s1, v_s2;
	logic signed [AW-1:0] a11_s1, a12_s1, a21_s1, a22_s1;
	logic signed [CW-1:0] xa_s1, ya_s1, xb_s1, yb_s1, xr_s1, yr_s1;
	logic [CW-2:0]        da_s1, db_s1, dr_s1;

	logic signed [AW-1:0] a11_s2, a12_s2, a21_s2, a22_s2;
	logic signed [SW-1:0] xa2_s2, ya2_s2, xb2_s2, yb2_s2, xr2_s2, yr2_s2;
	logic [RW-1:0]        da2_s2, db2_s2, dr2_s2;

	logic [BW-1:0] base;

	assign dxa = AW'(anchor_a_x) - AW'(ref_anchor_x);
	assign dya = AW'(anchor_a_y) - AW'(ref_anchor_y);
	assign dxb = AW'(anchor_b_x) - AW'(ref_anchor_x);
	assign dyb = AW'(anchor_b_y) - AW'(ref_anchor_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		a11_s1 <= dxa <<< 1;
		a12_s1 <= dya <<< 1;
		a21_s1 <= dxb <<< 1;
		a22_s1 <= dyb <<< 1;
		xa_s1  <= anchor_a_x;
		ya_s1  <= anchor_a_y;
		xb_s1  <= anchor_b_x;
		yb_s1  <= anchor_b_y;
		xr_s1  <= ref_anchor_x;
		yr_s1  <= ref_anchor_y;
		da_s1  <= range_a;
		db_s1  <= range_b;
		dr_s1  <= ref_range;

		a11_s2 <= a11_s1;
		a12_s2 <= a12_s1;
		a21_s2 <= a21_s1;
		a22_s2 <= a22_s1;
		xa2_s2 <= xa_s1 * xa_s1;
		ya2_s2 <= ya_s1 * ya_s1;
		xb2_s2 <= xb_s1 * xb_s1;
		yb2_s2 <= yb_s1 * yb_s1;
		xr2_s2 <= xr_s1 * xr_s1;
		yr2_s2 <= yr_s1 * yr_s1;
		da2_s2 <= da_s1 * da_s1;
		db2_s2 <= db_s1 * db_s1;
		dr2_s2 <= dr_s1 * dr_s1;
	end

	// squares are non-negative, so zero extension is exact
	assign base   = BW'(dr2_s2) - BW'(xr2_s2) - BW'(yr2_s2);
	assign out_b1 = base + BW'(xa2_s2) + BW'(ya2_s2) - BW'(da2_s2);
	assign out_b2 = base + BW'(xb2_s2) + BW'(yb2_s2) - BW'(db2_s2);

	assign out_valid = v_s2;
	assign out_a11   = a11_s2;
	assign out_a12   = a12_s2;
	assign out_a21   = a21_s2;
	assign out_a22   = a22_s2;
	assign inflight  = {1'b0, v_s1} + {1'b0, v_s2};

endmodule

/* rtl/trl3_back.sv */
// Back part: Cramer products, magnitudes, pipelined restoring divide and saturation.
module trl3_back #(
	parameter  int CW = trl3_pkg::COORD_WIDTH_DEF,
	localparam int AW = CW + 2,
	localparam int BW = 2 * CW + 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_avail,
	input  logic signed [AW-1:0] in_a11,
	input  logic signed [AW-1:0] in_a12,
	input  logic signed [AW-1:0] in_a21,
	input  logic signed [AW-1:0] in_a22,
	input  logic signed [BW-1:0] in_b1,
	input  logic signed [BW-1:0] in_b2,
	output logic                 in_take,
	output logic                 out_valid,
	output logic signed [CW-1:0] out_pos_x,
	output logic signed [CW-1:0] out_pos_y,
	output logic [1:0]           out_status
);

	localparam int HW  = BW - CW;        // high part of a right-hand side
	localparam int PL  = 2 * CW + 3;     // low partial product
	localparam int PH  = 2 * CW + 4;     // high partial product and det terms
	localparam int DW  = 2 * CW + 5;     // determinant
	localparam int NW  = 3 * CW + 4;     // numerator
	localparam int Q   = CW + 1;         // quotient bits kept
	localparam int CWD = DW + Q;         // divider compare width

	localparam logic [Q-1:0] HALF   = Q'(1) << (CW - 1);
	localparam logic [Q-1:0] POSMAX = HALF - Q'(1);

	typedef struct packed {
		logic sing;
		logic neg_x;
		logic neg_y;
		logic ovf_x;
		logic ovf_y;
	} side_t;

	// operand split
	logic signed [CW:0]   b1_lo, b2_lo;
	logic signed [HW-1:0] b1_hi, b2_hi;

	assign b1_lo = {1'b0, in_b1[CW-1:0]};
	assign b2_lo = {1'b0, in_b2[CW-1:0]};
	assign b1_hi = in_b1[BW-1:CW];
	assign b2_hi = in_b2[BW-1:CW];
	assign in_take = en && in_avail;

	logic                 v_s1, v_s2, v_s3;
	logic signed [PL-1:0] lx1_s1, lx2_s1, ly1_s1, ly2_s1;
	logic signed [PH-1:0] hx1_s1, hx2_s1, hy1_s1, hy2_s1, d1_s1, d2_s1;

	logic signed [PH-1:0] hx_d, hy_d;
	logic signed [PL-1:0] lx_d, ly_d;

	logic signed [NW-1:0] numx_s2, numy_s2;
	logic signed [DW-1:0] det_s2;

	logic [NW-1:0] nax_s3, nay_s3;
	logic [DW-1:0] dabs_s3;
	logic          sing_s3, negx_s3, negy_s3;

	// divider pipeline: index 0 holds the overflow-check stage
	logic [Q:0]     v_d;
	logic [CWD-1:0] rx_d [Q+1];
	logic [CWD-1:0] ry_d [Q+1];
	logic [Q-1:0]   qx_d [Q+1];
	logic [Q-1:0]   qy_d [Q+1];
	logic [DW-1:0]  dv_d [Q+1];
	side_t          sd_d [Q+1];

	assign hx_d = hx1_s1 - hx2_s1;
	assign hy_d = hy1_s1 - hy2_s1;
	assign lx_d = lx1_s1 - lx2_s1;
	assign ly_d = ly1_s1 - ly2_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_d  <= '0;
		end else if (en) begin
			v_s1 <= in_avail;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_d  <= {v_d[Q-1:0], v_s3};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lx1_s1 <= b1_lo * in_a22;
			lx2_s1 <= b2_lo * in_a12;
			hx1_s1 <= b1_hi * in_a22;
			hx2_s1 <= b2_hi * in_a12;
			ly1_s1 <= b2_lo * in_a11;
			ly2_s1 <= b1_lo * in_a21;
			hy1_s1 <= b2_hi * in_a11;
			hy2_s1 <= b1_hi * in_a21;
			d1_s1  <= in_a11 * in_a22;
			d2_s1  <= in_a12 * in_a21;

			numx_s2 <= (NW'(hx_d) <<< CW) + NW'(lx_d);
			numy_s2 <= (NW'(hy_d) <<< CW) + NW'(ly_d);
			det_s2  <= DW'(d1_s1) - DW'(d2_s1);

			sing_s3 <= (det_s2 == '0);
			negx_s3 <= numx_s2[NW-1] ^ det_s2[DW-1];
			negy_s3 <= numy_s2[NW-1] ^ det_s2[DW-1];
			nax_s3  <= numx_s2[NW-1] ? NW'(-numx_s2) : NW'(numx_s2);
			nay_s3  <= numy_s2[NW-1] ? NW'(-numy_s2) : NW'(numy_s2);
			dabs_s3 <= det_s2[DW-1] ? DW'(-det_s2) : DW'(det_s2);

			// quotient of 2^Q or more cannot fit the kept bits
			rx_d[0]       <= CWD'(nax_s3);
			ry_d[0]       <= CWD'(nay_s3);
			qx_d[0]       <= '0;
			qy_d[0]       <= '0;
			dv_d[0]       <= dabs_s3;
			sd_d[0].sing  <= sing_s3;
			sd_d[0].neg_x <= negx_s3;
			sd_d[0].neg_y <= negy_s3;
			sd_d[0].ovf_x <= CWD'(nax_s3) >= (CWD'(dabs_s3) << Q);
			sd_d[0].ovf_y <= CWD'(nay_s3) >= (CWD'(dabs_s3) << Q);
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar k = 0; k < Q; k++) begin : g_div
		localparam int SH = Q - 1 - k;
		logic [CWD-1:0] dsh;

		assign dsh = CWD'(dv_d[k]) << SH;

		always_ff @(posedge clk) begin
			if (en) begin
				if (rx_d[k] >= dsh) begin
					rx_d[k+1] <= rx_d[k] - dsh;
					qx_d[k+1] <= qx_d[k] | (Q'(1) << SH);
				end else begin
					rx_d[k+1] <= rx_d[k];
					qx_d[k+1] <= qx_d[k];
				end
				if (ry_d[k] >= dsh) begin
					ry_d[k+1] <= ry_d[k] - dsh;
					qy_d[k+1] <= qy_d[k] | (Q'(1) << SH);
				end else begin
					ry_d[k+1] <= ry_d[k];
					qy_d[k+1] <= qy_d[k];
				end
				dv_d[k+1] <= dv_d[k];
				sd_d[k+1] <= sd_d[k];
			end
		end
	end

	// saturation and result formatting
	side_t        sd_f;
	logic [Q-1:0] qx_f, qy_f, magx, magy;
	logic         sat_x, sat_y;

	assign sd_f  = sd_d[Q];
	assign qx_f  = qx_d[Q];
	assign qy_f  = qy_d[Q];
	assign sat_x = sd_f.ovf_x || (sd_f.neg_x ? (qx_f > HALF) : (qx_f > POSMAX));
	assign sat_y = sd_f.ovf_y || (sd_f.neg_y ? (qy_f > HALF) : (qy_f > POSMAX));
	assign magx  = sat_x ? (sd_f.neg_x ? HALF : POSMAX) : qx_f;
	assign magy  = sat_y ? (sd_f.neg_y ? HALF : POSMAX) : qy_f;

	always_comb begin
		if (sd_f.sing) begin
			out_pos_x  = '0;
			out_pos_y  = '0;
			out_status = trl3_pkg::ST_SINGULAR;
		end else begin
			out_pos_x  = sd_f.neg_x ? CW'(Q'(0) - magx) : CW'(magx);
			out_pos_y  = sd_f.neg_y ? CW'(Q'(0) - magy) : CW'(magy);
			out_status = (sat_x || sat_y) ? trl3_pkg::ST_SATURATED : trl3_pkg::ST_SOLVED;
		end
	end

	assign out_valid = en && v_d[Q];

endmodule
